// File: hw/rtl/asis_pkg.sv
`default_nettype none

package asis_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/asis_cell.sv
`default_nettype none

module asis_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  asis_pkg::cell_ctrl_t ctrl_i,
  input  asis_pkg::data_t     din_i,
  input  wire                 l_lt_i,
  input  wire                 l_valid_i,
  input  asis_pkg::data_t     l_val_i,
  input  wire                 r_valid_i,
  input  asis_pkg::data_t     r_val_i,
  output logic                lt_o,
  output logic                valid_o,
  output asis_pkg::data_t     val_o
);

  logic            valid_q, valid_d;
  asis_pkg::data_t val_q, val_d;

  // empty cells act as +infinity, so lt is monotone along the chain
  assign lt_o    = !valid_q || (din_i < val_q);
  assign valid_o = valid_q;
  assign val_o   = val_q;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.shift) begin
      valid_d = r_valid_i;
      val_d   = r_val_i;
    end else if (ctrl_i.ins && lt_o) begin
      valid_d = valid_q | l_valid_i;
      val_d   = l_lt_i ? l_val_i : din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ascending_integer_sorter_top.sv
// Ascending integer sorter.
// Input channel (in_valid_i/in_ready_o) takes one signed 32-bit value per
// request, with last_i marking the final element of a list. Output channel
// (out_valid_o/out_ready_i) returns the list in ascending order, one value
// per request, last_res_o on the final one and dropped_o set on every result
// when elements beyond MAX_ITEMS were discarded.
// Loading: one element per cycle; each element is inserted into a chain of
// MAX_ITEMS cells as it is accepted, every cell comparing in parallel.
// Unloading: starts the cycle after the last element is accepted; the chain
// shifts toward cell 0 once per accepted result.
// The input is not ready while a list is being unloaded.
// Receiver stall: cell 0 holds its value and the chain does not move.
// Reset empties the chain and clears the dropped flag; no clearing pass.
`default_nettype none

module ascending_integer_sorter_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire signed [31:0]    value_i,
  input  wire                  last_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic signed [31:0]   value_res_o,
  output logic                 last_res_o,
  output logic                 dropped_o
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   overflow_q;

  logic            lt    [MAX_ITEMS];
  logic            valid [MAX_ITEMS];
  asis_pkg::data_t val   [MAX_ITEMS];

  asis_pkg::cell_ctrl_t ctrl;
  logic in_acc, out_acc, full;

  assign full        = valid[MAX_ITEMS-1];
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_DRAIN) && valid[0];
  assign out_acc     = out_valid_o && out_ready_i;
  assign value_res_o = val[0];
  assign last_res_o  = !valid[1];
  assign dropped_o   = overflow_q;

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = out_acc;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic            l_lt, l_valid, r_valid;
    asis_pkg::data_t l_val, r_val;
    if (i == 0) begin : g_head
      assign l_lt    = 1'b0;
      assign l_valid = 1'b1;
      assign l_val   = value_i;
    end else begin : g_body
      assign l_lt    = lt[i-1];
      assign l_valid = valid[i-1];
      assign l_val   = val[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_val   = val[i];
    end else begin : g_mid
      assign r_valid = valid[i+1];
      assign r_val   = val[i+1];
    end
    asis_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .din_i     (value_i),
      .l_lt_i    (l_lt),
      .l_valid_i (l_valid),
      .l_val_i   (l_val),
      .r_valid_i (r_valid),
      .r_val_i   (r_val),
      .lt_o      (lt[i]),
      .valid_o   (valid[i]),
      .val_o     (val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      overflow_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc && full) begin
            overflow_q <= 1'b1;
          end
          if (in_acc && last_i) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc && last_res_o) begin
            state_q    <= ST_LOAD;
            overflow_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/asis_checker.sv
`default_nettype none

module asis_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input wire               last_i,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire signed [31:0] value_res_o,
  input wire               last_res_o,
  input wire               dropped_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while unloading");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> out_valid_o)
    else $error("no result after last element");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(value_res_o) && $stable(last_res_o))
    else $error("result changed under stall");

  a_end_of_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_res_o |=> !out_valid_o && in_ready_o)
    else $error("unload did not end after last result");

  a_mid_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_res_o |=> out_valid_o && $stable(dropped_o))
    else $error("list ended early or dropped flag changed");

endmodule

bind ascending_integer_sorter_top asis_checker u_asis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_res_o (value_res_o),
  .last_res_o  (last_res_o),
  .dropped_o   (dropped_o)
);

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;

  localparam int unsigned     MAX_ITEMS      = 64;
  localparam int unsigned     RANDOM_ITEMS   = 56;
  localparam int unsigned     WATCHDOG_LIMIT = 2000;
  localparam int unsigned     MAX_REPORTED   = 10;
  localparam int unsigned     SETTLE_CYCLES  = 16;
  localparam asis_pkg::data_t VALUE_MIN      = asis_pkg::data_t'(32'h8000_0000);
  localparam asis_pkg::data_t VALUE_MAX      = asis_pkg::data_t'(32'h7fff_ffff);

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    asis_pkg::data_t value;
    bit              last;
    bit              dropped;
  } sorted_res_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  asis_pkg::data_t value_i     = '0;
  logic            last_i      = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  asis_pkg::data_t value_res_o;
  logic            last_res_o;
  logic            dropped_o;

  // predictor state: current list kept in ascending order
  asis_pkg::data_t sorted_elems[$];
  bit              list_overflow = 1'b0;
  sorted_res_t     sorted_res_q[$];

  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned rx_cycle    = 0;
  rx_mode_e    rx_mode     = RX_ALWAYS;

  ascending_integer_sorter_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_res_o(value_res_o),
    .last_res_o (last_res_o),
    .dropped_o  (dropped_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void predict_element(asis_pkg::data_t v, bit l);
    int unsigned idx;
    int unsigned n;
    sorted_res_t r;
    if (sorted_elems.size() < MAX_ITEMS) begin
      idx = 0;
      while (idx < sorted_elems.size() && sorted_elems[idx] <= v) idx++;
      sorted_elems.insert(idx, v);
    end else begin
      list_overflow = 1'b1;
    end
    if (l) begin
      n = sorted_elems.size();
      for (int unsigned k = 0; k < n; k++) begin
        r.value   = sorted_elems[k];
        r.last    = (k + 1 == n);
        r.dropped = list_overflow;
        sorted_res_q.push_back(r);
      end
      sorted_elems.delete();
      list_overflow = 1'b0;
    end
  endfunction

  function automatic void check_result();
    sorted_res_t r;
    if (sorted_res_q.size() == 0) begin
      if (fail_count < MAX_REPORTED)
        $display("unexpected result: value %0d last %0b dropped %0b",
                 value_res_o, last_res_o, dropped_o);
      fail_count++;
    end else begin
      r = sorted_res_q.pop_front();
      if (value_res_o !== r.value || last_res_o !== r.last || dropped_o !== r.dropped) begin
        if (fail_count < MAX_REPORTED)
          $display("mismatch: expected value %0d last %0b dropped %0b, got %0d %0b %0b",
                   r.value, r.last, r.dropped, value_res_o, last_res_o, dropped_o);
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    bit progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        check_result();
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        predict_element(value_i, last_i);
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver stall pattern, switched among four modes at random
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_RANDOM:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready_i <= (rx_cycle % 8) < 5;
      default:     out_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic asis_pkg::data_t random_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return asis_pkg::data_t'($urandom_range(0, 6)) - asis_pkg::data_t'(3);
      default: return asis_pkg::data_t'($urandom);
    endcase
  endfunction

  task automatic send_element(input asis_pkg::data_t v, input bit l);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    value_i    = v;
    last_i     = l;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic send_list(input int unsigned len, input bit narrow);
    for (int unsigned i = 0; i < len; i++)
      send_element(narrow ? asis_pkg::data_t'($urandom_range(0, 6)) - asis_pkg::data_t'(3)
                          : random_value(),
                   i + 1 == len);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sorted_res_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_single_elements();
    send_element(VALUE_MIN, 1'b1);
    send_element(VALUE_MAX, 1'b1);
    send_element('0, 1'b1);
  endtask

  task automatic test_extreme_values();
    asis_pkg::data_t vals[9];
    vals = '{VALUE_MAX, VALUE_MIN, -1, 0, 1, asis_pkg::data_t'(32'haaaa_aaaa),
             asis_pkg::data_t'(32'h5555_5555), VALUE_MAX - 1, VALUE_MIN + 1};
    foreach (vals[i]) send_element(vals[i], i == 8);
  endtask

  task automatic test_equal_values();
    asis_pkg::data_t vals[6];
    vals = '{5, 5, -5, 5, -5, 5};
    foreach (vals[i]) send_element(vals[i], i == 5);
    wait_for_results();
  endtask

  // exactly full, then two past capacity (last request discarded too)
  task automatic test_store_capacity();
    for (int unsigned i = 0; i < MAX_ITEMS; i++)
      send_element(asis_pkg::data_t'(MAX_ITEMS - i) - asis_pkg::data_t'(32),
                   i + 1 == MAX_ITEMS);
    send_list(MAX_ITEMS + 2, 1'($urandom_range(0, 1)));
    wait_for_results();
  endtask

  task automatic test_random_lists();
    int unsigned sent;
    int unsigned lists;
    int unsigned len;
    sent  = 0;
    lists = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      send_list(len, $urandom_range(0, 2) == 0);
      sent += len;
      lists++;
      if (lists % 6 == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_elements();
    test_extreme_values();
    test_equal_values();
    test_store_capacity();
    test_random_lists();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && sorted_res_q.size() == 0 && sorted_elems.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/asis_pkg.sv
hw/rtl/asis_cell.sv
hw/rtl/ascending_integer_sorter_top.sv
hw/rtl/asis_checker.sv
tb/testbench.sv
